// ===== src/dmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmsc_pkg: shared types and constants for the delta-modulation sample channel
// Beat payload structs, request and register codes, the rate table.
// ----------------------------------------------------------------------------
package dmsc_pkg;

    // Request kinds carried in each input beat
    typedef enum logic [1:0] {
        REQ_REG_WRITE  = 2'd0,
        REQ_TICK       = 2'd1,
        REQ_BYTE_RET   = 2'd2,
        REQ_UNUSED     = 2'd3
    } req_type_t;

    // Register addresses for a register-write beat
    localparam logic [2:0] REG_FLAGS_RATE = 3'd0;
    localparam logic [2:0] REG_DIRECT_LVL = 3'd1;
    localparam logic [2:0] REG_START_ADDR = 3'd2;
    localparam logic [2:0] REG_LENGTH     = 3'd3;
    localparam logic [2:0] REG_ENABLE     = 3'd4;

    // Reset values and address window
    localparam logic [15:0] START_ADDR_RST = 16'hC000;
    localparam logic [11:0] START_LEN_RST  = 12'd1;
    localparam logic [15:0] ADDR_LAST      = 16'hFFFF;
    localparam logic [15:0] ADDR_WRAP      = 16'h8000;
    localparam logic [6:0]  LEVEL_UP_MAX   = 7'd125;
    localparam logic [6:0]  LEVEL_STEP     = 7'd2;
    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] reg_addr;
        logic [7:0] wr_data;
        logic [7:0] fetched_byte;
    } dmsc_in_t;

    typedef struct packed {
        logic [6:0]  level;
        logic        fetch_req;
        logic [15:0] fetch_addr;
    } dmsc_out_t;

    // Rate counter reload value per rate index
    function automatic logic [8:0] rate_period(input logic [3:0] idx);
        logic [8:0] val;
        case (idx)
            4'd0:    val = 9'd428;
            4'd1:    val = 9'd380;
            4'd2:    val = 9'd340;
            4'd3:    val = 9'd320;
            4'd4:    val = 9'd286;
            4'd5:    val = 9'd254;
            4'd6:    val = 9'd226;
            4'd7:    val = 9'd214;
            4'd8:    val = 9'd190;
            4'd9:    val = 9'd160;
            4'd10:   val = 9'd142;
            4'd11:   val = 9'd128;
            4'd12:   val = 9'd106;
            4'd13:   val = 9'd84;
            4'd14:   val = 9'd72;
            default: val = 9'd54;
        endcase
        return val;
    endfunction

endpackage

// ===== src/delta_modulation_sample_channel_unit.sv =====
// ----------------------------------------------------------------------------
// delta_modulation_sample_channel_unit: delta-modulation audio sample channel
// Register writes, ticks and returned sample bytes update a 7-bit level and
// raise memory fetch requests; one result beat per input beat.
// ----------------------------------------------------------------------------
// Every input beat (register write, tick or returned sample byte) produces one
// result beat carrying the level after that beat and, when the beat starts a
// memory read, the requested address (zero otherwise). The channel takes one
// beat per clock: the whole state update is a single pass of logic from the
// channel state into the result register, and a new beat is accepted whenever
// the result register is empty or being taken in the same cycle. The sample
// byte for a fetch comes back later as a separate returned-byte beat; a
// returned byte with no fetch outstanding is dropped.
module delta_modulation_sample_channel_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dmsc_pkg::dmsc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dmsc_pkg::dmsc_out_t m_data
);

    // Channel state
    logic        chan_enabled_reg,  chan_enabled_next;
    logic        loop_flag_reg,     loop_flag_next;
    logic [3:0]  rate_index_reg,    rate_index_next;
    logic [6:0]  out_level_reg,     out_level_next;
    logic [15:0] start_address_reg, start_address_next;
    logic [11:0] start_length_reg,  start_length_next;
    logic [15:0] cur_address_reg,   cur_address_next;
    logic [11:0] bytes_left_reg,    bytes_left_next;
    logic [8:0]  rate_counter_reg,  rate_counter_next;
    logic [3:0]  bits_left_reg,     bits_left_next;
    logic [7:0]  shifter_reg,       shifter_next;
    logic [7:0]  byte_buffer_reg,   byte_buffer_next;
    logic        buffer_full_reg,   buffer_full_next;
    logic        silent_reg,        silent_next;
    logic        fetch_pending_reg, fetch_pending_next;

    // Result register
    logic                m_valid_reg;
    dmsc_pkg::dmsc_out_t m_data_reg, m_data_next;

    logic s_fire;

    assign s_ready = ~m_valid_reg | m_ready;
    assign s_fire  = s_valid & s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Compute the next state and the result for the incoming beat
    always_comb begin
        logic        try_fetch;
        logic        fetch_go;
        logic [8:0]  rc_dec;
        logic [3:0]  bits_cur;
        logic [11:0] bl_dec;

        chan_enabled_next  = chan_enabled_reg;
        loop_flag_next     = loop_flag_reg;
        rate_index_next    = rate_index_reg;
        out_level_next     = out_level_reg;
        start_address_next = start_address_reg;
        start_length_next  = start_length_reg;
        cur_address_next   = cur_address_reg;
        bytes_left_next    = bytes_left_reg;
        rate_counter_next  = rate_counter_reg;
        bits_left_next     = bits_left_reg;
        shifter_next       = shifter_reg;
        byte_buffer_next   = byte_buffer_reg;
        buffer_full_next   = buffer_full_reg;
        silent_next        = silent_reg;
        fetch_pending_next = fetch_pending_reg;
        try_fetch          = 1'b0;
        rc_dec             = rate_counter_reg;
        bits_cur           = bits_left_reg;

        case (dmsc_pkg::req_type_t'(s_data.req_type))
            dmsc_pkg::REQ_REG_WRITE: begin
                case (s_data.reg_addr)
                    dmsc_pkg::REG_FLAGS_RATE: begin
                        loop_flag_next  = s_data.wr_data[6];
                        rate_index_next = s_data.wr_data[3:0];
                    end
                    dmsc_pkg::REG_DIRECT_LVL: begin
                        out_level_next = s_data.wr_data[6:0];
                    end
                    dmsc_pkg::REG_START_ADDR: begin
                        start_address_next = {2'b11, s_data.wr_data, 6'b0};
                    end
                    dmsc_pkg::REG_LENGTH: begin
                        start_length_next = {s_data.wr_data, 4'b0001};
                    end
                    dmsc_pkg::REG_ENABLE: begin
                        chan_enabled_next = s_data.wr_data[4];
                        if (!s_data.wr_data[4]) begin
                            bytes_left_next = '0;
                        end else if (bytes_left_reg == '0) begin
                            cur_address_next = start_address_reg;
                            bytes_left_next  = start_length_reg;
                            try_fetch        = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dmsc_pkg::REQ_TICK: begin
                if (chan_enabled_reg) begin
                    if (rate_counter_reg != '0) begin
                        rc_dec = rate_counter_reg - 9'd1;
                    end
                    rate_counter_next = rc_dec;
                    if (rc_dec == '0) begin
                        rate_counter_next = dmsc_pkg::rate_period(rate_index_reg);
                        // Load the next byte or go silent at a byte boundary
                        if (bits_left_reg == '0) begin
                            bits_cur = dmsc_pkg::BITS_PER_BYTE;
                            if (buffer_full_reg) begin
                                silent_next      = 1'b0;
                                shifter_next     = byte_buffer_reg;
                                buffer_full_next = 1'b0;
                                try_fetch        = 1'b1;
                            end else begin
                                silent_next = 1'b1;
                            end
                        end
                        // Step the level by the shifted-out bit, clamped
                        if (!silent_next) begin
                            if (shifter_next[0]) begin
                                if (out_level_reg <= dmsc_pkg::LEVEL_UP_MAX) begin
                                    out_level_next = out_level_reg + dmsc_pkg::LEVEL_STEP;
                                end
                            end else begin
                                if (out_level_reg >= dmsc_pkg::LEVEL_STEP) begin
                                    out_level_next = out_level_reg - dmsc_pkg::LEVEL_STEP;
                                end
                            end
                        end
                        shifter_next   = {1'b0, shifter_next[7:1]};
                        bits_left_next = bits_cur - 4'd1;
                    end
                end
            end
            dmsc_pkg::REQ_BYTE_RET: begin
                if (fetch_pending_reg) begin
                    byte_buffer_next   = s_data.fetched_byte;
                    buffer_full_next   = 1'b1;
                    fetch_pending_next = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // Issue a requested fetch when the buffer is empty, none is outstanding and bytes remain
        fetch_go = try_fetch & ~buffer_full_next & ~fetch_pending_next
                 & (bytes_left_next != '0);
        bl_dec   = bytes_left_next - 12'd1;
        m_data_next.level      = out_level_next;
        m_data_next.fetch_req  = fetch_go;
        m_data_next.fetch_addr = fetch_go ? cur_address_next : '0;
        if (fetch_go) begin
            fetch_pending_next = 1'b1;
            if (bl_dec == '0 && loop_flag_next) begin
                cur_address_next = start_address_next;
                bytes_left_next  = start_length_next;
            end else begin
                cur_address_next = (cur_address_next == dmsc_pkg::ADDR_LAST)
                                 ? dmsc_pkg::ADDR_WRAP : cur_address_next + 16'd1;
                bytes_left_next  = bl_dec;
            end
        end
    end

    // Advance the channel state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_enabled_reg  <= 1'b0;
            loop_flag_reg     <= 1'b0;
            rate_index_reg    <= '0;
            out_level_reg     <= '0;
            start_address_reg <= dmsc_pkg::START_ADDR_RST;
            start_length_reg  <= dmsc_pkg::START_LEN_RST;
            cur_address_reg   <= '0;
            bytes_left_reg    <= '0;
            rate_counter_reg  <= '0;
            bits_left_reg     <= '0;
            shifter_reg       <= '0;
            byte_buffer_reg   <= '0;
            buffer_full_reg   <= 1'b0;
            silent_reg        <= 1'b1;
            fetch_pending_reg <= 1'b0;
        end else if (s_fire) begin
            chan_enabled_reg  <= chan_enabled_next;
            loop_flag_reg     <= loop_flag_next;
            rate_index_reg    <= rate_index_next;
            out_level_reg     <= out_level_next;
            start_address_reg <= start_address_next;
            start_length_reg  <= start_length_next;
            cur_address_reg   <= cur_address_next;
            bytes_left_reg    <= bytes_left_next;
            rate_counter_reg  <= rate_counter_next;
            bits_left_reg     <= bits_left_next;
            shifter_reg       <= shifter_next;
            byte_buffer_reg   <= byte_buffer_next;
            buffer_full_reg   <= buffer_full_next;
            silent_reg        <= silent_next;
            fetch_pending_reg <= fetch_pending_next;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // Checks on the channel logic
    a_addr_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.fetch_req) |-> (m_data_reg.fetch_addr == '0))
        else $error("fetch address nonzero without a fetch request");

    a_addr_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.fetch_req) |-> m_data_reg.fetch_addr[15])
        else $error("fetch address below the sample window");

    a_fetch_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && m_data_next.fetch_req) |=> fetch_pending_reg)
        else $error("fetch issued without marking it outstanding");

    a_buf_xor_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !(buffer_full_reg && fetch_pending_reg))
        else $error("fetch outstanding while the byte buffer is full");

    a_len_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_left_reg != '0) |-> chan_enabled_reg)
        else $error("bytes remain on a disabled channel");

endmodule
